### rtl/translation_embedding_train_step_macros.svh
// assertion macros for the training block
`ifndef TRANSLATION_EMBEDDING_TRAIN_STEP_MACROS_SVH
`define TRANSLATION_EMBEDDING_TRAIN_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define TEP_ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TEP_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);
`else
`define TEP_ASSERT_HOLDS(lbl, prop, msg)
`define TEP_ASSERT_NEXT(lbl, cause, effect, msg)
`endif
`endif

### rtl/tep_pkg.sv
`default_nettype none
package tep_pkg;

  localparam logic [1:0] ACT_TRAIN = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic [1:0] TBL_ENTITY    = 2'd0;
  localparam logic [1:0] TBL_ATTRIBUTE = 2'd1;
  localparam logic [1:0] TBL_VALUE     = 2'd2;

  localparam logic [1:0] CFG_MARGIN = 2'd0;
  localparam logic [1:0] CFG_STEP   = 2'd1;
  localparam logic [1:0] CFG_DIMS   = 2'd2;

  localparam logic [19:0] MARGIN_RESET = 20'd16384;
  localparam logic [14:0] STEP_RESET   = 15'd16;
  localparam logic [8:0]  DIMS_RESET   = 9'd200;

  localparam logic [26:0] STEP_LOSS_MAX = 27'h7FFFFFF;
  localparam logic [39:0] LOSS_MAX      = 40'hFFFFFFFFFF;

  typedef struct packed {
    logic [1:0]         action;
    logic [11:0]        pos_entity;
    logic [12:0]        pos_value;
    logic [9:0]         pos_attribute;
    logic [11:0]        neg_entity;
    logic [12:0]        neg_value;
    logic [9:0]         neg_attribute;
    logic [1:0]         table_select;
    logic [12:0]        row_index;
    logic [7:0]         element_index;
    logic signed [15:0] element_value;
  } in_t;

  typedef struct packed {
    logic [26:0]        step_loss;
    logic               margin_violated;
    logic signed [15:0] read_value;
    logic [39:0]        loss_total;
  } out_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_WRAP, OP_SRP, OP_SAP, OP_SAN, OP_DECIDE, OP_URP, OP_UWP,
    OP_URN, OP_UWN, OP_ACCESS, OP_RDCAP, OP_CLEAR, OP_DONE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
  } ctl_t;

  typedef struct packed {
    logic wrapped;
    logic zero_dims;
    logic last_dim;
    logic violated;
  } stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] x);
    logic signed [15:0] r;
    if (x > 17'sd32767) r = 16'sh7FFF;
    else if (x < -17'sd32768) r = 16'sh8000;
    else r = x[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/tep_ctrl.sv
`default_nettype none
module tep_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [1:0]    action,
  input  wire tep_pkg::stat_t stat,
  output tep_pkg::ctl_t      ctl,
  output logic               busy
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_SRP, S_SAP, S_SAN, S_DECIDE, S_URP, S_UWP,
    S_URN, S_UWN, S_ACCESS, S_RDCAP, S_CLEAR, S_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            case (action)
              tep_pkg::ACT_TRAIN: state <= S_WRAP;
              tep_pkg::ACT_CLEAR: state <= S_CLEAR;
              default:            state <= S_ACCESS;
            endcase
          end
        end
        S_WRAP:   if (stat.wrapped) state <= stat.zero_dims ? S_DECIDE : S_SRP;
        S_SRP:    state <= S_SAP;
        S_SAP:    state <= S_SAN;
        S_SAN:    state <= stat.last_dim ? S_DECIDE : S_SRP;
        S_DECIDE: state <= S_URP;
        S_URP: begin
          if (!stat.violated || stat.zero_dims) state <= S_DONE;
          else state <= S_UWP;
        end
        S_UWP:    state <= S_URN;
        S_URN:    state <= S_UWN;
        S_UWN:    state <= stat.last_dim ? S_DONE : S_URP;
        S_ACCESS: state <= S_RDCAP;
        S_RDCAP:  state <= S_DONE;
        S_CLEAR:  state <= S_DONE;
        S_DONE:   state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    busy     = state != S_IDLE;
    ctl.load = (state == S_IDLE) && start;
    case (state)
      S_WRAP:   ctl.op = tep_pkg::OP_WRAP;
      S_SRP:    ctl.op = tep_pkg::OP_SRP;
      S_SAP:    ctl.op = tep_pkg::OP_SAP;
      S_SAN:    ctl.op = tep_pkg::OP_SAN;
      S_DECIDE: ctl.op = tep_pkg::OP_DECIDE;
      S_URP:    ctl.op = (stat.violated && !stat.zero_dims) ? tep_pkg::OP_URP
                                                             : tep_pkg::OP_IDLE;
      S_UWP:    ctl.op = tep_pkg::OP_UWP;
      S_URN:    ctl.op = tep_pkg::OP_URN;
      S_UWN:    ctl.op = tep_pkg::OP_UWN;
      S_ACCESS: ctl.op = tep_pkg::OP_ACCESS;
      S_RDCAP:  ctl.op = tep_pkg::OP_RDCAP;
      S_CLEAR:  ctl.op = tep_pkg::OP_CLEAR;
      S_DONE:   ctl.op = tep_pkg::OP_DONE;
      default:  ctl.op = tep_pkg::OP_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/tep_datapath.sv
`default_nettype none
module tep_datapath #(
  parameter int MAX_DIM        = 256,
  parameter int ENTITY_ROWS    = 4096,
  parameter int ATTRIBUTE_ROWS = 1024,
  parameter int VALUE_ROWS     = 8192
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [19:0]   cfg_data,
  input  wire tep_pkg::in_t  cmd,
  input  wire tep_pkg::ctl_t ctl,
  output tep_pkg::stat_t     stat,
  output logic               done,
  output tep_pkg::out_t      result
);

  localparam int IW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int NW  = $clog2(MAX_DIM + 1);
  localparam int SCW = 17 + NW;
  localparam int SW  = ((SCW > 27) ? SCW : 27) + 1;
  localparam int EN  = ENTITY_ROWS * MAX_DIM;
  localparam int AN  = ATTRIBUTE_ROWS * MAX_DIM;
  localparam int VN  = VALUE_ROWS * MAX_DIM;
  localparam int AWE = (EN > 1) ? $clog2(EN) : 1;
  localparam int AWA = (AN > 1) ? $clog2(AN) : 1;
  localparam int AWV = (VN > 1) ? $clog2(VN) : 1;

  logic [19:0] margin;
  logic [14:0] step_size;
  logic [8:0]  dims_in_use;

  tep_pkg::in_t req;
  logic [11:0] pe, ne;
  logic [12:0] pv, nv;
  logic [9:0]  pa, na;
  logic [NW-1:0] d;
  logic [SCW-1:0] sp, sn;
  logic [26:0] loss;
  logic        viol;
  logic signed [15:0] rd;
  logic [39:0] total;

  logic signed [15:0] emem [EN];
  logic signed [15:0] amem [AN];
  logic signed [15:0] vmem [VN];
  logic signed [15:0] erd, ard, vrd;

  logic [AWE-1:0] e_addr;
  logic [AWA-1:0] a_addr;
  logic [AWV-1:0] v_addr;
  logic we_e, we_a, we_v;
  logic signed [15:0] e_wd, a_wd, v_wd;

  logic [NW-1:0] n_eff;
  logic use_neg, el_ok, e_ok, a_ok, v_ok, up;
  logic signed [17:0] x;
  logic [16:0] absx;
  logic signed [16:0] st;
  logic [SW-1:0] spm, diff;
  logic gt;
  logic [26:0] loss_c;
  logic [40:0] tsum;
  int er, ar, vr, idx;

  always_comb begin
    n_eff = (int'(dims_in_use) > MAX_DIM) ? NW'(MAX_DIM) : NW'(dims_in_use);
    use_neg = (ctl.op == tep_pkg::OP_SAP) || (ctl.op == tep_pkg::OP_URN) ||
              (ctl.op == tep_pkg::OP_UWN);
    el_ok = int'(req.element_index) < MAX_DIM;
    e_ok = el_ok && (req.table_select == tep_pkg::TBL_ENTITY) &&
           (int'(req.row_index) < ENTITY_ROWS);
    a_ok = el_ok && (req.table_select == tep_pkg::TBL_ATTRIBUTE) &&
           (int'(req.row_index) < ATTRIBUTE_ROWS);
    v_ok = el_ok && (req.table_select == tep_pkg::TBL_VALUE) &&
           (int'(req.row_index) < VALUE_ROWS);
    if (ctl.op == tep_pkg::OP_ACCESS) begin
      er  = e_ok ? int'(req.row_index) : 0;
      ar  = a_ok ? int'(req.row_index) : 0;
      vr  = v_ok ? int'(req.row_index) : 0;
      idx = el_ok ? int'(req.element_index) : 0;
    end else begin
      er  = use_neg ? int'(ne) : int'(pe);
      ar  = use_neg ? int'(na) : int'(pa);
      vr  = use_neg ? int'(nv) : int'(pv);
      idx = int'(d[IW-1:0]);
    end
    e_addr = AWE'(er * MAX_DIM + idx);
    a_addr = AWA'(ar * MAX_DIM + idx);
    v_addr = AWV'(vr * MAX_DIM + idx);

    x = 18'(vrd) - 18'(erd) - 18'(ard);
    absx = x[17] ? 17'(-x) : 17'(x);
    up = (x > 18'sd0) ^ (ctl.op == tep_pkg::OP_UWN);
    st = up ? $signed({2'b00, step_size}) : -$signed({2'b00, step_size});

    we_e = 1'b0;
    we_a = 1'b0;
    we_v = 1'b0;
    e_wd = tep_pkg::sat16(17'(erd) + st);
    a_wd = tep_pkg::sat16(17'(ard) + st);
    v_wd = tep_pkg::sat16(17'(vrd) - st);
    case (ctl.op)
      tep_pkg::OP_UWP, tep_pkg::OP_UWN: begin
        we_e = 1'b1;
        we_a = 1'b1;
        we_v = 1'b1;
      end
      tep_pkg::OP_ACCESS: begin
        we_e = (req.action == tep_pkg::ACT_WRITE) && e_ok;
        we_a = (req.action == tep_pkg::ACT_WRITE) && a_ok;
        we_v = (req.action == tep_pkg::ACT_WRITE) && v_ok;
        e_wd = req.element_value;
        a_wd = req.element_value;
        v_wd = req.element_value;
      end
      default: ;
    endcase

    spm = SW'(sp) + SW'(margin);
    gt = spm > SW'(sn);
    diff = spm - SW'(sn);
    loss_c = (diff > SW'(tep_pkg::STEP_LOSS_MAX)) ? tep_pkg::STEP_LOSS_MAX : diff[26:0];
    tsum = {1'b0, total} + 41'(loss_c);

    stat.wrapped = (int'(pe) < ENTITY_ROWS) && (int'(ne) < ENTITY_ROWS) &&
                   (int'(pv) < VALUE_ROWS) && (int'(nv) < VALUE_ROWS) &&
                   (int'(pa) < ATTRIBUTE_ROWS) && (int'(na) < ATTRIBUTE_ROWS);
    stat.zero_dims = n_eff == '0;
    stat.last_dim  = (d + NW'(1)) == n_eff;
    stat.violated  = viol;

    done = ctl.op == tep_pkg::OP_DONE;
    result.step_loss       = loss;
    result.margin_violated = viol;
    result.read_value      = rd;
    result.loss_total      = total;
  end

  always_ff @(posedge clk) begin
    if (we_e) emem[e_addr] <= e_wd;
    erd <= emem[e_addr];
  end

  always_ff @(posedge clk) begin
    if (we_a) amem[a_addr] <= a_wd;
    ard <= amem[a_addr];
  end

  always_ff @(posedge clk) begin
    if (we_v) vmem[v_addr] <= v_wd;
    vrd <= vmem[v_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      margin      <= tep_pkg::MARGIN_RESET;
      step_size   <= tep_pkg::STEP_RESET;
      dims_in_use <= tep_pkg::DIMS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tep_pkg::CFG_MARGIN: margin      <= cfg_data;
        tep_pkg::CFG_STEP:   step_size   <= cfg_data[14:0];
        tep_pkg::CFG_DIMS:   dims_in_use <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      viol  <= 1'b0;
    end else begin
      case (ctl.op)
        tep_pkg::OP_DECIDE: begin
          if (gt) begin
            viol  <= 1'b1;
            total <= tsum[40] ? tep_pkg::LOSS_MAX : tsum[39:0];
          end
        end
        tep_pkg::OP_CLEAR: total <= '0;
        default: if (ctl.load) viol <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req  <= cmd;
      pe   <= cmd.pos_entity;
      pv   <= cmd.pos_value;
      pa   <= cmd.pos_attribute;
      ne   <= cmd.neg_entity;
      nv   <= cmd.neg_value;
      na   <= cmd.neg_attribute;
      d    <= '0;
      sp   <= '0;
      sn   <= '0;
      loss <= '0;
      rd   <= '0;
    end else begin
      case (ctl.op)
        tep_pkg::OP_WRAP: begin
          if (int'(pe) >= ENTITY_ROWS) pe <= pe - 12'(ENTITY_ROWS);
          if (int'(ne) >= ENTITY_ROWS) ne <= ne - 12'(ENTITY_ROWS);
          if (int'(pv) >= VALUE_ROWS) pv <= pv - 13'(VALUE_ROWS);
          if (int'(nv) >= VALUE_ROWS) nv <= nv - 13'(VALUE_ROWS);
          if (int'(pa) >= ATTRIBUTE_ROWS) pa <= pa - 10'(ATTRIBUTE_ROWS);
          if (int'(na) >= ATTRIBUTE_ROWS) na <= na - 10'(ATTRIBUTE_ROWS);
        end
        tep_pkg::OP_SAP: sp <= sp + SCW'(absx);
        tep_pkg::OP_SAN: begin
          sn <= sn + SCW'(absx);
          d  <= d + NW'(1);
        end
        tep_pkg::OP_DECIDE: begin
          d <= '0;
          if (gt) loss <= loss_c;
        end
        tep_pkg::OP_UWN: d <= d + NW'(1);
        tep_pkg::OP_RDCAP: begin
          if (req.action == tep_pkg::ACT_READ) begin
            if (e_ok) rd <= erd;
            else if (a_ok) rd <= ard;
            else if (v_ok) rd <= vrd;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/translation_embedding_train_step.sv
// channel   ports                          beat taken when
// cmd       start, busy, cmd               start high and busy low
// config    cfg_we, cfg_index, cfg_data    cfg_we high
// result    done, result                   done high, one cycle
//
// a train beat scores all n dims, then updates them when the margin is violated and n > 0
// (n = dims in use, capped at MAX_DIM), with one port per table memory
// out-of-range row indices wrap by row-count subtraction, none needed at default sizes
// reset clears the fsm and loss total and restores config defaults; table contents stay undefined
// the result cannot be stalled: done is a one-cycle strobe
`default_nettype none
`include "translation_embedding_train_step_macros.svh"
module translation_embedding_train_step #(
  parameter int MAX_DIM        = 256,
  parameter int ENTITY_ROWS    = 4096,
  parameter int ATTRIBUTE_ROWS = 1024,
  parameter int VALUE_ROWS     = 8192
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire tep_pkg::in_t cmd,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [19:0]  cfg_data,
  output logic              done,
  output tep_pkg::out_t     result
);

  tep_pkg::ctl_t  ctl;
  tep_pkg::stat_t stat;

  tep_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (cmd.action),
    .stat   (stat),
    .ctl    (ctl),
    .busy   (busy)
  );

  tep_datapath #(
    .MAX_DIM        (MAX_DIM),
    .ENTITY_ROWS    (ENTITY_ROWS),
    .ATTRIBUTE_ROWS (ATTRIBUTE_ROWS),
    .VALUE_ROWS     (VALUE_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .ctl       (ctl),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

  `TEP_ASSERT_HOLDS(a_done_busy, !done || busy, "result beat outside a busy item")
  `TEP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not start work")
  `TEP_ASSERT_NEXT(a_done_single, done, !done && !busy, "result strobe longer than one cycle")
  `TEP_ASSERT_HOLDS(a_loss_viol, !done || result.margin_violated || result.step_loss == '0,
    "loss reported without violation")

endmodule
`default_nettype wire

### tb/tb_translation_embedding_train_step.sv
`default_nettype none
module tb_translation_embedding_train_step;

  localparam int DIMS_MAX = 256;
  localparam int INIT_DIMS = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  tep_pkg::in_t  cmd = '0;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_index = tep_pkg::CFG_MARGIN;
  logic [19:0]   cfg_data = '0;
  logic          done;
  tep_pkg::out_t result;

  translation_embedding_train_step dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  always #1 clk = ~clk;

  // predictor state
  logic signed [15:0] ent_mem [int];
  logic signed [15:0] att_mem [int];
  logic signed [15:0] val_mem [int];
  logic [39:0] loss_acc;
  logic [19:0] cur_margin;
  logic [14:0] cur_step;
  logic [8:0]  cur_dims;

  tep_pkg::out_t expected_q [$];
  int   mismatches = 0;
  int   idle_pct = 0;
  int   stall_count = 0;

  logic [11:0] ent_pool [4] = '{12'd0, 12'd1, 12'd2, 12'd4095};
  logic [9:0]  att_pool [4] = '{10'd0, 10'd1, 10'd2, 10'd1023};
  logic [12:0] val_pool [4] = '{13'd0, 13'd1, 13'd2, 13'd8191};

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    mismatches++;
  endtask

  function automatic logic signed [15:0] clamp16(int x);
    if (x > 32767) return 16'sh7FFF;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic int resid(int e, int v, int a, int d);
    return int'(val_mem[v + d]) - int'(ent_mem[e + d]) - int'(att_mem[a + d]);
  endfunction

  function automatic longint l1_score(int e, int v, int a, int n);
    longint s;
    int x;
    s = 0;
    for (int d = 0; d < n; d++) begin
      x = resid(e, v, a, d);
      s += (x < 0) ? -x : x;
    end
    return s;
  endfunction

  function automatic void nudge_triple(int e, int v, int a, int d, int sgn);
    int t;
    t = (resid(e, v, a, d) > 0 ? 1 : -1) * sgn * int'(cur_step);
    att_mem[a + d] = clamp16(int'(att_mem[a + d]) + t);
    ent_mem[e + d] = clamp16(int'(ent_mem[e + d]) + t);
    val_mem[v + d] = clamp16(int'(val_mem[v + d]) - t);
  endfunction

  function automatic tep_pkg::out_t predict_step(tep_pkg::in_t c);
    tep_pkg::out_t o;
    int pe, pv, pa, ne, nv, na, n, key;
    longint sp, sn, loss, acc;
    bit ok;
    o = '0;
    case (c.action)
      tep_pkg::ACT_TRAIN: begin
        pe = int'(c.pos_entity) * DIMS_MAX;
        pv = int'(c.pos_value) * DIMS_MAX;
        pa = int'(c.pos_attribute) * DIMS_MAX;
        ne = int'(c.neg_entity) * DIMS_MAX;
        nv = int'(c.neg_value) * DIMS_MAX;
        na = int'(c.neg_attribute) * DIMS_MAX;
        n = (int'(cur_dims) > DIMS_MAX) ? DIMS_MAX : int'(cur_dims);
        sp = l1_score(pe, pv, pa, n);
        sn = l1_score(ne, nv, na, n);
        if (sp + longint'(cur_margin) > sn) begin
          loss = sp + longint'(cur_margin) - sn;
          if (loss > longint'(tep_pkg::STEP_LOSS_MAX)) loss = longint'(tep_pkg::STEP_LOSS_MAX);
          o.step_loss = loss[26:0];
          o.margin_violated = 1'b1;
          acc = longint'(loss_acc) + loss;
          if (acc > longint'(tep_pkg::LOSS_MAX)) acc = longint'(tep_pkg::LOSS_MAX);
          loss_acc = acc[39:0];
          for (int d = 0; d < n; d++) begin
            nudge_triple(pe, pv, pa, d, 1);
            nudge_triple(ne, nv, na, d, -1);
          end
        end
      end
      tep_pkg::ACT_WRITE, tep_pkg::ACT_READ: begin
        key = int'(c.row_index) * DIMS_MAX + int'(c.element_index);
        ok = 1'b1;
        case (c.table_select)
          tep_pkg::TBL_ENTITY: ok = (int'(c.row_index) < 4096);
          tep_pkg::TBL_ATTRIBUTE: ok = (int'(c.row_index) < 1024);
          tep_pkg::TBL_VALUE: ok = 1'b1;
          default: ok = 1'b0;
        endcase
        if (ok) begin
          if (c.action == tep_pkg::ACT_WRITE) begin
            case (c.table_select)
              tep_pkg::TBL_ENTITY: ent_mem[key] = c.element_value;
              tep_pkg::TBL_ATTRIBUTE: att_mem[key] = c.element_value;
              default: val_mem[key] = c.element_value;
            endcase
          end else begin
            case (c.table_select)
              tep_pkg::TBL_ENTITY: o.read_value = ent_mem[key];
              tep_pkg::TBL_ATTRIBUTE: o.read_value = att_mem[key];
              default: o.read_value = val_mem[key];
            endcase
          end
        end
      end
      default: loss_acc = '0;
    endcase
    o.loss_total = loss_acc;
    return o;
  endfunction

  // random filler for fields an action ignores
  function automatic tep_pkg::in_t noise_cmd(logic [1:0] act);
    tep_pkg::in_t c;
    c.action = act;
    c.pos_entity = 12'($urandom);
    c.pos_value = 13'($urandom);
    c.pos_attribute = 10'($urandom);
    c.neg_entity = 12'($urandom);
    c.neg_value = 13'($urandom);
    c.neg_attribute = 10'($urandom);
    c.table_select = 2'($urandom);
    c.row_index = 13'($urandom);
    c.element_index = 8'($urandom);
    c.element_value = 16'($urandom);
    return c;
  endfunction

  function automatic tep_pkg::in_t train_cmd();
    tep_pkg::in_t c;
    c = noise_cmd(tep_pkg::ACT_TRAIN);
    c.pos_entity = ent_pool[$urandom_range(3)];
    c.pos_value = val_pool[$urandom_range(3)];
    c.pos_attribute = att_pool[$urandom_range(3)];
    c.neg_entity = ent_pool[$urandom_range(3)];
    c.neg_value = val_pool[$urandom_range(3)];
    c.neg_attribute = att_pool[$urandom_range(3)];
    return c;
  endfunction

  // access to an initialized element, or one the block must ignore
  function automatic tep_pkg::in_t access_cmd(logic [1:0] act, bit stray);
    tep_pkg::in_t c;
    c = noise_cmd(act);
    if (!stray) begin
      c.table_select = 2'($urandom_range(2));
      c.element_index = 8'($urandom_range(INIT_DIMS - 1));
      case (c.table_select)
        tep_pkg::TBL_ENTITY: c.row_index = 13'(ent_pool[$urandom_range(3)]);
        tep_pkg::TBL_ATTRIBUTE: c.row_index = 13'(att_pool[$urandom_range(3)]);
        default: c.row_index = val_pool[$urandom_range(3)];
      endcase
    end else begin
      case ($urandom_range(2))
        0: c.table_select = 2'd3;
        1: begin
          c.table_select = tep_pkg::TBL_ENTITY;
          c.row_index = 13'($urandom_range(8191, 4096));
        end
        default: begin
          c.table_select = tep_pkg::TBL_ATTRIBUTE;
          c.row_index = 13'($urandom_range(8191, 1024));
        end
      endcase
    end
    return c;
  endfunction

  task automatic send_beat(tep_pkg::in_t c);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    cmd <= c;
    while (busy) @(negedge clk);
    @(posedge clk);
    expected_q.insert(expected_q.size(), predict_step(c));
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_q.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tep_pkg::CFG_MARGIN: cur_margin = val;
      tep_pkg::CFG_STEP: cur_step = val[14:0];
      default: cur_dims = val[8:0];
    endcase
  endtask

  task automatic set_config(logic [19:0] m, logic [14:0] s, logic [8:0] d);
    drain();
    write_reg(tep_pkg::CFG_MARGIN, m);
    write_reg(tep_pkg::CFG_STEP, {5'd0, s});
    write_reg(tep_pkg::CFG_DIMS, {11'd0, d});
  endtask

  task automatic test_table_init();
    tep_pkg::in_t c;
    idle_pct = 10;
    for (int t = 0; t < 3; t++) begin
      for (int r = 0; r < 4; r++) begin
        for (int el = 0; el < INIT_DIMS; el++) begin
          c = noise_cmd(tep_pkg::ACT_WRITE);
          c.table_select = t[1:0];
          c.row_index = (t == 0) ? 13'(ent_pool[r]) : (t == 1) ? 13'(att_pool[r])
                                                              : val_pool[r];
          c.element_index = el[7:0];
          case ($urandom_range(9))
            0: c.element_value = 16'sh7FFF;
            1: c.element_value = 16'sh8000;
            default: c.element_value = 16'($urandom);
          endcase
          send_beat(c);
        end
      end
    end
  endtask

  task automatic test_directed();
    tep_pkg::in_t c;
    idle_pct = 0;
    // reset margin and step, all-zero rows and all-max rows
    set_config(tep_pkg::MARGIN_RESET, tep_pkg::STEP_RESET, 9'(INIT_DIMS));
    c = noise_cmd(tep_pkg::ACT_TRAIN);
    {c.pos_entity, c.pos_value, c.pos_attribute} = '0;
    {c.neg_entity, c.neg_value, c.neg_attribute} = '0;
    send_beat(c);
    c.pos_entity = 12'd4095; c.pos_value = 13'd8191; c.pos_attribute = 10'd1023;
    c.neg_entity = 12'd4095; c.neg_value = 13'd8191; c.neg_attribute = 10'd1023;
    send_beat(c);
    send_beat(access_cmd(tep_pkg::ACT_READ, 1'b0));
    send_beat(access_cmd(tep_pkg::ACT_READ, 1'b1));
    send_beat(access_cmd(tep_pkg::ACT_WRITE, 1'b1));
    c = access_cmd(tep_pkg::ACT_WRITE, 1'b0);
    c.element_value = 16'sh7FFF;
    send_beat(c);
    c.action = tep_pkg::ACT_READ;
    send_beat(c);
    c.action = tep_pkg::ACT_WRITE;
    c.element_value = 16'sh8000;
    send_beat(c);
    c.action = tep_pkg::ACT_READ;
    send_beat(c);
    send_beat(noise_cmd(tep_pkg::ACT_CLEAR));
    // saturating steps, big margin
    set_config(20'hFFFFF, 15'h7FFF, 9'(INIT_DIMS));
    for (int i = 0; i < 3; i++) send_beat(train_cmd());
    // zero margin and step, no dims
    set_config(20'd0, 15'd0, 9'd0);
    send_beat(train_cmd());
    set_config(20'd5, 15'd1, 9'd0);
    send_beat(train_cmd());
    // full initialized depth
    set_config(20'd16384, 15'd300, 9'(INIT_DIMS));
    send_beat(train_cmd());
    set_config(20'd0, 15'd16, 9'd1);
    for (int i = 0; i < 3; i++) send_beat(train_cmd());
    send_beat(noise_cmd(tep_pkg::ACT_CLEAR));
    send_beat(train_cmd());
  endtask

  task automatic test_random(int count, int pct);
    int k;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        k = int'($urandom_range(19));
        set_config((k < 3) ? 20'hFFFFF : (k < 5) ? 20'd0 : 20'($urandom_range(200000)),
                   (k == 7) ? 15'h7FFF : (k == 8) ? 15'd0 : 15'($urandom_range(4096)),
                   (k == 9) ? 9'(INIT_DIMS) : (k == 10) ? 9'd0 : (k == 11) ? 9'd1
                            : 9'($urandom_range(16, 1)));
        idle_pct = pct;
      end
      k = int'($urandom_range(99));
      if (k < 60) send_beat(train_cmd());
      else if (k < 75) send_beat(access_cmd(tep_pkg::ACT_WRITE, $urandom_range(3) == 0));
      else if (k < 92) send_beat(access_cmd(tep_pkg::ACT_READ, $urandom_range(3) == 0));
      else send_beat(noise_cmd(tep_pkg::ACT_CLEAR));
    end
  endtask

  // result checking
  always @(posedge clk) begin
    tep_pkg::out_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (result.step_loss !== want.step_loss)
          report_mismatch("step_loss", result.step_loss, want.step_loss);
        if (result.margin_violated !== want.margin_violated)
          report_mismatch("margin_violated", result.margin_violated, want.margin_violated);
        if (result.read_value !== want.read_value)
          report_mismatch("read_value", result.read_value, want.read_value);
        if (result.loss_total !== want.loss_total)
          report_mismatch("loss_total", result.loss_total, want.loss_total);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
        $display("translation_embedding_train_step regression: fail");
        $finish;
      end
    end
  end

  initial begin
    loss_acc = '0;
    cur_margin = tep_pkg::MARGIN_RESET;
    cur_step = tep_pkg::STEP_RESET;
    cur_dims = tep_pkg::DIMS_RESET;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_table_init();
    test_directed();
    test_random(180, 36);
    test_random(180, 59);
    test_random(180, 0);
    drain();
    repeat (50) @(negedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("translation_embedding_train_step regression: pass");
    end else begin
      $display("translation_embedding_train_step regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

### translation_embedding_train_step.f
+incdir+rtl
rtl/tep_pkg.sv
rtl/tep_ctrl.sv
rtl/tep_datapath.sv
rtl/translation_embedding_train_step.sv
tb/tb_translation_embedding_train_step.sv
